>>> src/sos_pkg.sv
// Package for the sweep object segmenter: sizes, object descriptor type and
// the half-angle tangent table, built at elaboration from fixed-point CORDIC steps.
// No dependencies; every other file of the block imports it.
`default_nettype none

package sos_pkg;

  localparam int SWEEP_SAMPLES = 256;
  localparam int DIST_BITS     = 16;
  localparam int CUT_W         = 16;
  localparam int ANGLE_W       = 8;
  localparam int BIS_W         = 9;
  localparam int IDX_W         = $clog2(SWEEP_SAMPLES);
  localparam int CMP_W         = (DIST_BITS > CUT_W) ? DIST_BITS : CUT_W;

  localparam logic [CUT_W-1:0] CUTOFF_RESET = CUT_W'(3200);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int TAN_ENTRIES  = 180;
  localparam int TAN_W        = 32;
  localparam int CORDIC_STEPS = 16;
  localparam int FRAC_BITS    = 16;
  localparam int PROD_W       = DIST_BITS + TAN_W;

  localparam logic [ANGLE_W:0] HALF_TURN = (ANGLE_W + 1)'(180);
  localparam logic [ANGLE_W:0] FULL_TURN = (ANGLE_W + 1)'(360);

  typedef logic [TAN_W-1:0] tan_tbl_t [TAN_ENTRIES];

  typedef struct packed {
    logic [ANGLE_W-1:0]   span;
    logic [BIS_W-1:0]     bisector;
    logic [DIST_BITS-1:0] mid_dist;
  } obj_t;

  typedef struct packed {
    logic [QCNT_W-1:0] level;
    logic              empty;
  } qstat_t;

  localparam longint ATAN_UNITS [CORDIC_STEPS] = '{
    64'sd2949120, 64'sd1740967, 64'sd919879, 64'sd466945,
    64'sd234379,  64'sd117266,  64'sd58665,  64'sd29335,
    64'sd14668,   64'sd7334,    64'sd3667,   64'sd1833,
    64'sd917,     64'sd458,     64'sd229,    64'sd115
  };

  // Evaluated only at elaboration: rotate by k/2 degrees, then take y/x in Q16.16
  // by restoring long division.
  function automatic tan_tbl_t build_tan_tbl();
    tan_tbl_t          tbl;
    longint            x;
    longint            y;
    longint            z;
    longint            dx;
    longint            dy;
    longint unsigned   num;
    longint unsigned   den;
    longint unsigned   rem;
    logic [63:0]       quo;
    for (int k = 0; k < TAN_ENTRIES; k++) begin
      x = longint'(1) <<< 28;
      y = 0;
      z = longint'(k) * 32768;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - ATAN_UNITS[i];
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + ATAN_UNITS[i];
        end
      end
      if (y < 0) begin
        y = 0;
      end
      if (x <= 0) begin
        tbl[k] = '1;
      end else begin
        num = longint'(y) * 65536;
        den = x;
        rem = 0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
          rem = (rem << 1) | longint'(num[b]);
          if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
          end
        end
        tbl[k] = quo[TAN_W-1:0];
      end
    end
    return tbl;
  endfunction

  localparam tan_tbl_t TAN_Q = build_tan_tbl();

endpackage

`default_nettype wire

>>> src/sos_front.sv
// Front end: accepts samples, stores distances, tracks the open object and
// emits one object descriptor per close into the queue. Depends on sos_pkg.
`default_nettype none

module sos_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  input  wire logic [sos_pkg::CUT_W-1:0]      cfg_cutoff_distance_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [sos_pkg::ANGLE_W-1:0]    sample_angle_i,
  input  wire logic [sos_pkg::DIST_BITS-1:0]  sample_distance_i,
  input  wire logic                           sweep_end_i,
  input  wire sos_pkg::qstat_t                q_stat_i,
  output logic                                push_o,
  output sos_pkg::obj_t                       push_obj_o
);
  import sos_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SWEEP_SAMPLES - 1);

  logic [DIST_BITS-1:0] store_mem [SWEEP_SAMPLES];

  logic [CUT_W-1:0]     cutoff_q;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic                 open_q, open_d;
  logic [IDX_W-1:0]     open_idx_q, open_idx_d;
  logic [ANGLE_W-1:0]   open_ang_q, open_ang_d;
  logic                 s1_valid_q;
  logic [ANGLE_W-1:0]   s1_span_q;
  logic [BIS_W-1:0]     s1_bis_q;
  logic                 fwd_q;
  logic [DIST_BITS-1:0] fwd_dist_q;
  logic [DIST_BITS-1:0] rd_q;

  logic                 acc;
  logic [IDX_W:0]       idx_sum;
  logic [IDX_W-1:0]     mid_idx;
  logic [CMP_W-1:0]     dist_x, cut_x;
  logic                 opens, closes;
  logic [ANGLE_W-1:0]   span;
  logic [BIS_W-1:0]     bis;

  assign in_stall_o = (QCNT_W'({1'b0, q_stat_i.level}) + QCNT_W'(s1_valid_q))
                      >= QCNT_W'(QDEPTH);
  assign acc        = in_valid_i && !in_stall_o;
  assign idx_sum    = {1'b0, open_idx_q} + {1'b0, idx_q};
  assign mid_idx    = idx_sum[IDX_W:1];
  assign dist_x     = CMP_W'(sample_distance_i);
  assign cut_x      = CMP_W'(cutoff_q);
  assign opens      = !open_q && (dist_x < cut_x);
  assign closes     = open_q && (dist_x > cut_x);
  assign span       = (sample_angle_i > open_ang_q) ? (sample_angle_i - open_ang_q)
                                                     : (open_ang_q - sample_angle_i);
  assign bis        = {1'b0, open_ang_q} + {2'b00, span[ANGLE_W-1:1]};

  always_comb begin
    idx_d      = idx_q;
    open_d     = open_q;
    open_idx_d = open_idx_q;
    open_ang_d = open_ang_q;
    if (acc) begin
      if (opens) begin
        open_d     = 1'b1;
        open_idx_d = idx_q;
        open_ang_d = sample_angle_i;
      end else if (closes) begin
        open_d = 1'b0;
      end
      if (sweep_end_i) begin
        open_d = 1'b0;
        idx_d  = '0;
      end else if (idx_q == LAST_IDX) begin
        idx_d = '0;
      end else begin
        idx_d = idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q   <= CUTOFF_RESET;
      idx_q      <= '0;
      open_q     <= 1'b0;
      open_idx_q <= '0;
      open_ang_q <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cutoff_q <= cfg_cutoff_distance_i;
      end
      idx_q      <= idx_d;
      open_q     <= open_d;
      open_idx_q <= open_idx_d;
      open_ang_q <= open_ang_d;
      s1_valid_q <= acc && closes;
    end
  end

  // The middle entry may be the one written by this very beat; forward it.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      store_mem[idx_q] <= sample_distance_i;
      rd_q             <= store_mem[mid_idx];
      fwd_q            <= (mid_idx == idx_q);
      fwd_dist_q       <= sample_distance_i;
      s1_span_q        <= span;
      s1_bis_q         <= bis;
    end
  end

  assign push_o              = s1_valid_q;
  assign push_obj_o.span     = s1_span_q;
  assign push_obj_o.bisector = s1_bis_q;
  assign push_obj_o.mid_dist = fwd_q ? fwd_dist_q : rd_q;

endmodule

`default_nettype wire

>>> src/sos_queue.sv
// Small FIFO of object descriptors between the front end and the width unit.
// Depends on sos_pkg; the front end reserves space, so a push never finds it full.
`default_nettype none

module sos_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire sos_pkg::obj_t  push_obj_i,
  input  wire logic           pop_i,
  output sos_pkg::obj_t       head_o,
  output sos_pkg::qstat_t     stat_o
);
  import sos_pkg::*;

  obj_t              entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      level_q <= level_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_obj_i;
    end
  end

  assign head_o       = entry_q[rd_ptr_q];
  assign stat_o.level = level_q;
  assign stat_o.empty = (level_q == '0);

endmodule

`default_nettype wire

>>> src/sos_back.sv
// Back end: tangent lookup, distance-by-tangent multiply, rounding and
// saturation, and the output register. Depends on sos_pkg.
`default_nettype none

module sos_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire sos_pkg::obj_t                  head_i,
  input  wire sos_pkg::qstat_t                q_stat_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [sos_pkg::ANGLE_W-1:0]         span_degrees_o,
  output logic [sos_pkg::BIS_W-1:0]           bisector_angle_o,
  output logic [sos_pkg::DIST_BITS-1:0]       middle_distance_o,
  output logic [sos_pkg::DIST_BITS-1:0]       object_width_o,
  output logic                                width_saturated_o
);
  import sos_pkg::*;

  localparam logic [PROD_W:0] ROUND = (PROD_W + 1)'(1) << (FRAC_BITS - 1);

  logic                 adv;
  logic [ANGLE_W:0]     span_x;
  logic [ANGLE_W-1:0]   tan_idx;

  logic                 a_valid_q;
  obj_t                 a_obj_q;
  logic [TAN_W-1:0]     a_tan_q;
  logic                 a_half_q;

  logic                 b_valid_q;
  obj_t                 b_obj_q;
  logic [PROD_W-1:0]    b_prod_q;
  logic                 b_half_q;

  logic [PROD_W:0]      rsum;
  logic                 ovf;
  logic [DIST_BITS-1:0] w_d;
  logic                 sat_d;

  logic                 out_valid_q;
  obj_t                 out_obj_q;
  logic [DIST_BITS-1:0] width_q;
  logic                 sat_q;

  assign adv     = !(out_valid_q && out_stall_i);
  assign pop_o   = adv && !q_stat_i.empty;
  assign span_x  = {1'b0, head_i.span};
  assign tan_idx = (span_x < HALF_TURN) ? head_i.span : ANGLE_W'(FULL_TURN - span_x);

  assign rsum = {b_prod_q, 1'b0} + ROUND;
  assign ovf  = |rsum[PROD_W:FRAC_BITS+DIST_BITS];

  always_comb begin
    if (b_half_q) begin
      sat_d = (b_obj_q.mid_dist != '0);
      w_d   = sat_d ? '1 : '0;
    end else if (ovf) begin
      sat_d = 1'b1;
      w_d   = '1;
    end else begin
      sat_d = 1'b0;
      w_d   = rsum[FRAC_BITS+DIST_BITS-1:FRAC_BITS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q   <= pop_o;
      b_valid_q   <= a_valid_q;
      out_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_obj_q   <= head_i;
      a_tan_q   <= TAN_Q[tan_idx];
      a_half_q  <= (span_x == HALF_TURN);
      b_obj_q   <= a_obj_q;
      b_prod_q  <= PROD_W'(a_obj_q.mid_dist) * PROD_W'(a_tan_q);
      b_half_q  <= a_half_q;
      out_obj_q <= b_obj_q;
      width_q   <= w_d;
      sat_q     <= sat_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign span_degrees_o    = out_obj_q.span;
  assign bisector_angle_o  = out_obj_q.bisector;
  assign middle_distance_o = out_obj_q.mid_dist;
  assign object_width_o    = width_q;
  assign width_saturated_o = sat_q;

endmodule

`default_nettype wire

>>> src/sweep_object_segmenter.sv
// A closing sample's result passes the front-end register, the object queue, then
// the back end's tangent, product and output registers.
// Throughput: one sample per cycle; the four-entry object queue with credit from
// the front end sets when the input stalls behind a stalled output.
// Reset is asynchronous and clears control state and the cutoff (3200) at once;
// the distance store holds no reset value and needs no clearing pass.
`default_nettype none

module sweep_object_segmenter (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [sos_pkg::CUT_W-1:0]      cfg_cutoff_distance_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [sos_pkg::ANGLE_W-1:0]    sample_angle_i,
  input  wire logic [sos_pkg::DIST_BITS-1:0]  sample_distance_i,
  input  wire logic                           sweep_end_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [sos_pkg::ANGLE_W-1:0]         span_degrees_o,
  output logic [sos_pkg::BIS_W-1:0]           bisector_angle_o,
  output logic [sos_pkg::DIST_BITS-1:0]       middle_distance_o,
  output logic [sos_pkg::DIST_BITS-1:0]       object_width_o,
  output logic                                width_saturated_o
);
  import sos_pkg::*;

  logic   push;
  obj_t   push_obj;
  logic   pop;
  obj_t   head;
  qstat_t q_stat;

  assign cfg_ready_o = 1'b1;

  sos_front u_front (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_cutoff_distance_i (cfg_cutoff_distance_i),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .sample_angle_i        (sample_angle_i),
    .sample_distance_i     (sample_distance_i),
    .sweep_end_i           (sweep_end_i),
    .q_stat_i              (q_stat),
    .push_o                (push),
    .push_obj_o            (push_obj)
  );

  sos_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_obj_i (push_obj),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (q_stat)
  );

  sos_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_i            (head),
    .q_stat_i          (q_stat),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .span_degrees_o    (span_degrees_o),
    .bisector_angle_o  (bisector_angle_o),
    .middle_distance_o (middle_distance_o),
    .object_width_o    (object_width_o),
    .width_saturated_o (width_saturated_o)
  );

endmodule

`default_nettype wire

>>> src/sos_checker.sv
// Port-level checker for the sweep object segmenter and its bind to the top level.
// Depends on sos_pkg for port widths.
`default_nettype none

module sos_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  input  wire logic [sos_pkg::ANGLE_W-1:0]    span_degrees_o,
  input  wire logic [sos_pkg::BIS_W-1:0]      bisector_angle_o,
  input  wire logic [sos_pkg::DIST_BITS-1:0]  middle_distance_o,
  input  wire logic [sos_pkg::DIST_BITS-1:0]  object_width_o,
  input  wire logic                           width_saturated_o
);
  import sos_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(span_degrees_o) &&
      $stable(bisector_angle_o) && $stable(middle_distance_o) &&
      $stable(object_width_o) && $stable(width_saturated_o))
    else $error("Result beat changed while stalled.");

  a_sat_all_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && width_saturated_o |-> object_width_o == '1)
    else $error("Saturated width is not all ones.");

  a_half_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && {1'b0, span_degrees_o} == HALF_TURN |->
      width_saturated_o == (middle_distance_o != '0))
    else $error("Half-turn span saturation does not follow the distance.");

  a_zero_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && middle_distance_o == '0 |->
      object_width_o == '0 && !width_saturated_o)
    else $error("Zero distance gave a nonzero width.");

endmodule

bind sweep_object_segmenter sos_checker u_sos_checker (.*);

`default_nettype wire
